// ===== hdl/assert_macros.svh =====
// assertion macros shared by the circular autocorrelation rtl
// no dependencies; assertions compile away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// ===== hdl/caci_pkg.sv =====
// shared types and constants for the circular autocorrelation integral unit
// no dependencies
package caci_pkg;

   localparam int LAG_BITS      = 10;
   localparam int CORR_BITS     = 48;
   localparam int ACC_BITS      = 64;
   localparam int SCALE_BITS    = 32;
   localparam int HALF_BITS     = 32;
   localparam int FRAC_BITS     = 16;
   localparam int DIV_STEPS     = 64;
   localparam int REQ_USER_BITS = 2;
   localparam int RSP_DATA_BITS = 128;
   localparam int RSP_PAD_BITS  = RSP_DATA_BITS - LAG_BITS - CORR_BITS - ACC_BITS;

   localparam int USER_FUNC  = 0;
   localparam int USER_FIRST = 1;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_LAG  = 1'b1;

   localparam logic [SCALE_BITS-1:0] SCALE_RESET = 32'd65536;
   localparam logic [ACC_BITS-1:0]   INT_MAX     = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam logic [ACC_BITS-1:0]   INT_MIN     = {1'b1, {(ACC_BITS-1){1'b0}}};

   typedef struct packed {
      logic                done;
      logic [ACC_BITS-1:0] quotient;
   } div_result_type;

   typedef struct packed {
      logic                done;
      logic [ACC_BITS-1:0] integral;
   } scale_result_type;

endpackage

// ===== hdl/circular_autocorrelation_integral_unit.sv =====
// circular autocorrelation with saturating running integral, top level
// a load beat is written directly into the sample memory; a lag request with n samples runs
// through n multiply-accumulate products, then the divider, the scaler and the output register
// one item at a time: no new request is taken until the result is loaded for output, and a held
// result stalls the input. reset is synchronous: count, lag and integral clear, scale returns
// to 1.0, the sample memory is not cleared
`include "assert_macros.svh"

module circular_autocorrelation_integral_unit #(
   parameter int MAX_SAMPLES = 1024,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // tdata: sample
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       req_tdata,
   // tuser: func, first
   input  logic [caci_pkg::REQ_USER_BITS-1:0]     req_tuser,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // tdata: lag, correlation, integral, zero pad
   output logic [caci_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   output logic                                   rsp_tlast,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   input  logic                                   csr_wr_en,
   input  logic [caci_pkg::SCALE_BITS-1:0]        csr_wr_data
);

   localparam int CW = $clog2(MAX_SAMPLES + 1);
   localparam int AB = $clog2(MAX_SAMPLES);
   localparam int PW = 2 * SAMPLE_BITS;
   localparam int XW = caci_pkg::ACC_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DIV,
      ST_SCALE,
      ST_HOLD
   } state_type;

   state_type                        state_ff;
   logic [CW-1:0]                    count_ff;
   logic [CW-1:0]                    lag_ff;
   logic [XW-1:0]                    integral_ff;
   logic [caci_pkg::SCALE_BITS-1:0]  scale_ff;
   logic [CW-1:0]                    issue_ff;
   logic [CW-1:0]                    j_ff;
   logic                             rd_vld_ff;
   logic                             prod_vld_ff;
   logic signed [PW-1:0]             prod_ff;
   logic [XW-1:0]                    acc_ff;
   logic                             neg_ff;
   logic [XW-1:0]                    corr_ff;
   logic                             rsp_valid_ff;
   logic [caci_pkg::LAG_BITS-1:0]    rsp_lag_ff;
   logic [caci_pkg::CORR_BITS-1:0]   rsp_corr_ff;
   logic [XW-1:0]                    rsp_int_ff;
   logic                             rsp_last_ff;

   logic                             req_accept;
   logic                             func;
   logic                             first;
   logic [CW-1:0]                    count_base;
   logic                             wr_en;
   logic [CW-1:0]                    final_lag;
   logic                             lag_ok;
   logic [CW-1:0]                    j_start;
   logic [CW-1:0]                    j_inc;
   logic [CW-1:0]                    j_in;
   logic                             issuing;
   logic                             mac_done;
   logic [XW-1:0]                    acc_in;
   logic [XW-1:0]                    acc_mag;
   logic                             out_free;
   logic                             rsp_load;
   logic [SAMPLE_BITS-1:0]           rd_data_a;
   logic [SAMPLE_BITS-1:0]           rd_data_b;
   logic                             div_start;
   caci_pkg::div_result_type         div_res;
   caci_pkg::scale_result_type       scl_res;

   always_comb begin
      req_accept = req_tvalid && req_tready;
      func       = req_tuser[caci_pkg::USER_FUNC];
      first      = req_tuser[caci_pkg::USER_FIRST];
      count_base = first ? '0 : count_ff;
      wr_en      = req_accept && (func == caci_pkg::FUNC_LOAD)
                   && (count_base < CW'(MAX_SAMPLES));
      final_lag  = (count_ff >> 1) + CW'(1);
      lag_ok     = (count_ff != '0) && (lag_ff <= final_lag);
      j_start    = (lag_ff >= count_ff) ? lag_ff - count_ff : lag_ff;
      j_inc      = j_ff + CW'(1);
      j_in       = (j_inc == count_ff) ? '0 : j_inc;
      issuing    = issue_ff != count_ff;
      mac_done   = !issuing && !rd_vld_ff && !prod_vld_ff;
      acc_in     = acc_ff + XW'(prod_ff);
      acc_mag    = acc_ff[XW-1] ? XW'(0) - acc_ff : acc_ff;
      div_start  = (state_ff == ST_MAC) && mac_done;
      out_free   = !rsp_valid_ff || rsp_tready;
      rsp_load   = (state_ff == ST_HOLD) && out_free;
   end

   caci_store #(
      .DEPTH     (MAX_SAMPLES),
      .WIDTH     (SAMPLE_BITS),
      .ADDR_BITS (AB)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (count_base[AB-1:0]),
      .wr_data   (req_tdata[SAMPLE_BITS-1:0]),
      .rd_addr_a (issue_ff[AB-1:0]),
      .rd_addr_b (j_ff[AB-1:0]),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   caci_div #(
      .DIVISOR_BITS (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_mag),
      .divisor  (count_ff),
      .result   (div_res)
   );

   caci_scale u_scale (
      .clock    (clock),
      .reset    (reset),
      .start    (div_res.done),
      .mag      (div_res.quotient),
      .neg      (neg_ff),
      .scale    (scale_ff),
      .integral (integral_ff),
      .result   (scl_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         lag_ff       <= '0;
         integral_ff  <= '0;
         scale_ff     <= caci_pkg::SCALE_RESET;
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         issue_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            scale_ff <= csr_wr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  if (func == caci_pkg::FUNC_LOAD) begin
                     if (first) begin
                        lag_ff      <= '0;
                        integral_ff <= '0;
                     end
                     if (wr_en) begin
                        count_ff <= count_base + CW'(1);
                     end else begin
                        count_ff <= count_base;
                     end
                  end else if (lag_ok) begin
                     issue_ff <= '0;
                     j_ff     <= j_start;
                     acc_ff   <= '0;
                     state_ff <= ST_MAC;
                  end
               end
            end
            ST_MAC: begin
               rd_vld_ff   <= issuing;
               prod_vld_ff <= rd_vld_ff;
               if (issuing) begin
                  issue_ff <= issue_ff + CW'(1);
                  j_ff     <= j_in;
               end
               if (rd_vld_ff) begin
                  prod_ff <= signed'(rd_data_a) * signed'(rd_data_b);
               end
               if (prod_vld_ff) begin
                  acc_ff <= acc_in;
               end
               if (mac_done) begin
                  neg_ff   <= acc_ff[XW-1];
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_res.done) begin
                  corr_ff  <= neg_ff ? XW'(0) - div_res.quotient : div_res.quotient;
                  state_ff <= ST_SCALE;
               end
            end
            ST_SCALE: begin
               if (scl_res.done) begin
                  state_ff <= ST_HOLD;
               end
            end
            ST_HOLD: begin
               if (out_free) begin
                  rsp_lag_ff   <= caci_pkg::LAG_BITS'(lag_ff);
                  rsp_corr_ff  <= corr_ff[caci_pkg::CORR_BITS-1:0];
                  rsp_int_ff   <= scl_res.integral;
                  rsp_last_ff  <= lag_ff == final_lag;
                  integral_ff  <= scl_res.integral;
                  lag_ff       <= lag_ff + CW'(1);
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{caci_pkg::RSP_PAD_BITS{1'b0}}, rsp_int_ff, rsp_corr_ff, rsp_lag_ff};

   `ASSERT_IMPL(a_mac_nonempty, clock, reset, state_ff == ST_MAC, count_ff != '0)
   `ASSERT_IMPL(a_issue_bound, clock, reset, state_ff == ST_MAC, issue_ff <= count_ff)
   `ASSERT_IMPL(a_lag_bound, clock, reset, 1'b1, lag_ff <= final_lag + CW'(1))
   `ASSERT_IMPL(a_div_in_div, clock, reset, div_res.done, state_ff == ST_DIV)
   `ASSERT_NEXT(a_scale_to_hold, clock, reset, scl_res.done, state_ff == ST_HOLD)

endmodule

// ===== hdl/caci_store.sv =====
// sample memory: one write port, two registered read ports
// depends on nothing
module caci_store #(
   parameter int DEPTH      = 1024,
   parameter int WIDTH      = 24,
   parameter int ADDR_BITS  = 10
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr_a,
   input  logic [ADDR_BITS-1:0] rd_addr_b,
   output logic [WIDTH-1:0]     rd_data_a,
   output logic [WIDTH-1:0]     rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== hdl/caci_div.sv =====
// restoring divider, one quotient bit per cycle, 64-bit dividend
// depends on caci_pkg
module caci_div #(
   parameter int DIVISOR_BITS = 11
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [caci_pkg::ACC_BITS-1:0]  dividend,
   input  logic [DIVISOR_BITS-1:0]        divisor,
   output caci_pkg::div_result_type       result
);

   localparam int STEP_BITS = $clog2(caci_pkg::DIV_STEPS + 1);

   logic                          busy_ff;
   logic                          done_ff;
   logic [STEP_BITS-1:0]          cnt_ff;
   logic [caci_pkg::ACC_BITS-1:0] quo_ff;
   logic [DIVISOR_BITS-1:0]       rem_ff;

   logic [DIVISOR_BITS:0]         rem_shift;
   logic [DIVISOR_BITS:0]         rem_diff;
   logic                          fits;
   logic [DIVISOR_BITS-1:0]       rem_in;
   logic [caci_pkg::ACC_BITS-1:0] quo_in;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[caci_pkg::ACC_BITS-1]};
      rem_diff  = rem_shift - {1'b0, divisor};
      fits      = rem_shift >= {1'b0, divisor};
      rem_in    = fits ? rem_diff[DIVISOR_BITS-1:0] : rem_shift[DIVISOR_BITS-1:0];
      quo_in    = {quo_ff[caci_pkg::ACC_BITS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == STEP_BITS'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= STEP_BITS'(caci_pkg::DIV_STEPS);
            quo_ff  <= dividend;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff - STEP_BITS'(1);
            if (cnt_ff == STEP_BITS'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign result.done     = done_ff;
   assign result.quotient = quo_ff;

endmodule

// ===== hdl/caci_scale.sv =====
// q16 scaling with saturation and saturating add into the running integral
// depends on caci_pkg; one shared 32x32 multiplier used twice
module caci_scale (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [caci_pkg::ACC_BITS-1:0]    mag,
   input  logic                             neg,
   input  logic [caci_pkg::SCALE_BITS-1:0]  scale,
   input  logic [caci_pkg::ACC_BITS-1:0]    integral,
   output caci_pkg::scale_result_type       result
);

   localparam int AW = caci_pkg::ACC_BITS;
   localparam int HW = caci_pkg::HALF_BITS;
   localparam int FW = caci_pkg::FRAC_BITS;

   logic [4:0]                      step_ff;
   logic                            done_ff;
   logic [AW-1:0]                   mag_ff;
   logic                            neg_ff;
   logic [caci_pkg::SCALE_BITS-1:0] scl_ff;
   logic [AW-1:0]                   lo_ff;
   logic [AW-1:0]                   hi_ff;
   logic [AW-1:0]                   r_ff;
   logic [AW-1:0]                   val_ff;
   logic [AW-1:0]                   sum_ff;

   logic [HW-1:0]                   mul_a;
   logic [AW-1:0]                   prod;
   logic [AW:0]                     r_sum;
   logic [AW-1:0]                   r_in;
   logic [AW-1:0]                   val_in;
   logic [AW-1:0]                   add_raw;
   logic                            add_ovf;
   logic [AW-1:0]                   sum_in;

   always_comb begin
      mul_a   = step_ff[0] ? mag_ff[HW-1:0] : mag_ff[AW-1:HW];
      prod    = AW'(mul_a) * AW'(scl_ff);
      r_sum   = {1'b0, hi_ff[AW-FW-1:0], {FW{1'b0}}} + {{(FW+1){1'b0}}, lo_ff[AW-1:FW]};
      if ((|hi_ff[AW-1:AW-FW-1]) || r_sum[AW]) begin
         r_in = '1;
      end else begin
         r_in = r_sum[AW-1:0];
      end
      if (neg_ff) begin
         val_in = r_ff[AW-1] ? caci_pkg::INT_MIN : AW'(0) - r_ff;
      end else begin
         val_in = r_ff[AW-1] ? caci_pkg::INT_MAX : r_ff;
      end
      add_raw = integral + val_ff;
      add_ovf = (integral[AW-1] == val_ff[AW-1]) && (add_raw[AW-1] != integral[AW-1]);
      if (add_ovf) begin
         sum_in = integral[AW-1] ? caci_pkg::INT_MIN : caci_pkg::INT_MAX;
      end else begin
         sum_in = add_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= {step_ff[3:0], start};
         done_ff <= step_ff[4];
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mag_ff <= mag;
         neg_ff <= neg;
         scl_ff <= scale;
      end
      if (step_ff[0]) begin
         lo_ff <= prod;
      end
      if (step_ff[1]) begin
         hi_ff <= prod;
      end
      if (step_ff[2]) begin
         r_ff <= r_in;
      end
      if (step_ff[3]) begin
         val_ff <= val_in;
      end
      if (step_ff[4]) begin
         sum_ff <= sum_in;
      end
   end

   assign result.done     = done_ff;
   assign result.integral = sum_ff;

endmodule
